// File: design/akd_pkg.sv
`default_nettype none
package akd_pkg;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic        [15:0] heading_angle;
      logic signed [31:0] speed;
      logic signed [31:0] throttle_cmd;
      logic signed [31:0] roll_rate_cmd;
      logic signed [31:0] pitch_rate_cmd;
   } req_type;

   typedef struct packed {
      logic signed [31:0] north_rate;
      logic signed [31:0] east_rate;
      logic signed [31:0] down_rate;
      logic signed [31:0] roll_rate_out;
      logic signed [31:0] pitch_rate_out;
      logic signed [31:0] yaw_rate_out;
      logic signed [31:0] speed_rate_out;
      logic               yaw_saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_MAX_ROLL_RATE    = 3'd0,
      CSR_MAX_PITCH_RATE   = 3'd1,
      CSR_BASE_TURN_RADIUS = 3'd2,
      CSR_RADIUS_SLOPE     = 3'd3,
      CSR_REFERENCE_SPEED  = 3'd4
   } csr_index_type;

   // Taylor coefficients (pi/2)^k/k! in Q30, odd powers 1..11
   localparam logic [31:0] SIN_COEF [0:5] = '{
      32'd1686629713, 32'd693598669, 32'd85569304,
      32'd5026996, 32'd172273, 32'd3864
   };

   localparam int SIN_STAGES = 7;
   localparam logic [63:0] HALF30 = 64'h0000_0000_2000_0000;

   // |a|*|s| rounded half up by >>30, sign restored
   function automatic logic signed [34:0] mul_q30(input logic signed [32:0] a,
                                                   input logic signed [31:0] s);
      logic [32:0] am;
      logic [31:0] sm;
      logic [63:0] p;
      logic [34:0] m;
      am = a[32] ? 33'(-a) : 33'(a);
      sm = s[31] ? 32'(-s) : 32'(s);
      p  = ({31'b0, am} * {32'b0, sm}) + HALF30;
      m  = {1'b0, p[63:30]};
      return (a[32] ^ s[31]) ? 35'(-m) : 35'(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

// File: design/aircraft_kinematic_derivative_unit.sv
`default_nettype none
// Fixed-wing kinematic derivative unit.
// One vehicle state per req beat (roll, pitch, heading, speed and three
// commands); one rsp beat of derivatives per req beat, in order.
// Configuration: csr_wr_en writes csr_wdata into register csr_index
// (0 roll rate limit, 1 pitch rate limit, 2 base turn radius,
// 3 radius slope, 4 reference speed); write only while the pipe is empty.
// Throughput: one beat per cycle unless stalled (below), through a 43-stage pipeline:
// an input register, seven stages of the sine polynomial, a multiply stage, a combine
// stage, an overflow check, 31 restoring-divide stages (one quotient bit each)
// for the yaw rate, and the output register.
// Stall: each stage holds when it and every stage after it are full and
// rsp_ready is low; bubbles close up, so req_ready stays high while any
// stage is empty.
// Reset: clears all valid bits and loads the register defaults.
module aircraft_kinematic_derivative_unit
   import akd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int ST_TRIG = SIN_STAGES;
   localparam int ST_MUL  = ST_TRIG + 1;
   localparam int ST_POS  = ST_MUL + 1;
   localparam int ST_CHK  = ST_POS + 1;
   localparam int QW      = 31;
   localparam int ST_DIV0 = ST_CHK + 1;
   localparam int ST_OUT  = ST_DIV0 + QW;
   localparam int NST     = ST_OUT + 1;
   localparam int DW      = 93;
   localparam int NW      = 94;
   localparam int CW      = DW + QW;

   localparam logic signed [31:0] THR_LIM = 32'sd6553600;

   typedef struct packed {
      logic signed [31:0] spd;
      logic signed [31:0] rr;
      logic signed [31:0] pr;
      logic signed [31:0] spdr;
      logic signed [31:0] ch;
      logic signed [31:0] sh;
      logic signed [31:0] north;
      logic signed [31:0] east;
      logic signed [31:0] down;
      logic signed [31:0] yaw;
      logic signed [63:0] prod;
      logic signed [63:0] len;
      logic               lenpos;
      logic signed [32:0] xy;
      logic [61:0]        num;
      logic               numnz;
      logic               neg;
      logic [62:0]        dlo;
      logic [61:0]        dhi;
      logic [DW-1:0]      d;
      logic [NW-1:0]      rem;
      logic [QW-1:0]      q;
      logic               ovf;
      logic               flag;
   } lane_type;

   logic [30:0]        max_roll_ff;
   logic [30:0]        max_pitch_ff;
   logic signed [31:0] base_radius_ff;
   logic signed [31:0] radius_slope_ff;
   logic signed [31:0] ref_speed_ff;

   req_type            s0_ff;
   lane_type           lane_ff [1:NST-1];
   lane_type           lane_in [1:NST-1];
   logic [NST-1:0]     vld_ff;
   logic [NST-1:0]     en;

   logic signed [31:0] sin_roll, cos_roll, sin_pitch, cos_pitch, sin_head, cos_head;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         max_roll_ff     <= 31'd65536;
         max_pitch_ff    <= 31'd65536;
         base_radius_ff  <= 32'sd3276800;
         radius_slope_ff <= 32'sd0;
         ref_speed_ff    <= 32'sd3276800;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_ROLL_RATE:    max_roll_ff     <= csr_wdata[30:0];
            CSR_MAX_PITCH_RATE:   max_pitch_ff    <= csr_wdata[30:0];
            CSR_BASE_TURN_RADIUS: base_radius_ff  <= csr_wdata;
            CSR_RADIUS_SLOPE:     radius_slope_ff <= csr_wdata;
            CSR_REFERENCE_SPEED:  ref_speed_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // a stage may load if any stage from it to the output is empty
   always_comb begin
      for (int i = 0; i < NST; i++) begin
         en[i] = rsp_ready || ((~vld_ff >> i) != '0);
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= req_data;
      end
      for (int i = 1; i < NST; i++) begin
         if (en[i]) begin
            lane_ff[i] <= lane_in[i];
         end
      end
   end

   // ---------------- sine / cosine ----------------
   akd_sin_pipe u_sin_roll (.clock(clock), .en(en[ST_TRIG:1]),
      .angle(s0_ff.roll_angle), .sin_q30(sin_roll));
   akd_sin_pipe u_cos_roll (.clock(clock), .en(en[ST_TRIG:1]),
      .angle(16'(s0_ff.roll_angle + 16'd16384)), .sin_q30(cos_roll));
   akd_sin_pipe u_sin_pitch (.clock(clock), .en(en[ST_TRIG:1]),
      .angle(s0_ff.pitch_angle), .sin_q30(sin_pitch));
   akd_sin_pipe u_cos_pitch (.clock(clock), .en(en[ST_TRIG:1]),
      .angle(16'(s0_ff.pitch_angle + 16'd16384)), .sin_q30(cos_pitch));
   akd_sin_pipe u_sin_head (.clock(clock), .en(en[ST_TRIG:1]),
      .angle(s0_ff.heading_angle), .sin_q30(sin_head));
   akd_sin_pipe u_cos_head (.clock(clock), .en(en[ST_TRIG:1]),
      .angle(16'(s0_ff.heading_angle + 16'd16384)), .sin_q30(cos_head));

   // ---------------- datapath ----------------
   logic signed [31:0] thr_c, lim_w, cmd_w;
   logic [31:0]        thr_m;
   logic [56:0]        q5_w;
   logic signed [32:0] diff_w;
   logic signed [64:0] prod_w;
   logic signed [65:0] sum_w;
   logic [31:0]        spd_m;
   logic [30:0]        sr_m, cr_m;
   logic [62:0]        num_w;
   logic [NW-1:0]      dsum_w;
   logic [CW-1:0]      r_w, t_w, sub_w;
   logic signed [31:0] sat_w;

   always_comb begin
      for (int i = 2; i < NST; i++) begin
         lane_in[i] = lane_ff[i-1];
      end

      // stage 1: command clamps, throttle/5, radius slope term
      lane_in[1] = '0;
      lane_in[1].spd = s0_ff.speed;
      thr_c = s0_ff.throttle_cmd;
      if (thr_c > THR_LIM) begin
         thr_c = THR_LIM;
      end else if (thr_c < -THR_LIM) begin
         thr_c = -THR_LIM;
      end
      thr_m = thr_c[31] ? 32'(-thr_c) : 32'(thr_c);
      // exact x/5 for x < 2^23
      q5_w = {34'b0, thr_m[22:0]} * 57'd3435973837;
      lane_in[1].spdr = thr_c[31] ? -{9'b0, q5_w[56:34]} : {9'b0, q5_w[56:34]};

      lim_w = {1'b0, max_roll_ff};
      cmd_w = s0_ff.roll_rate_cmd;
      if (cmd_w > lim_w) begin
         cmd_w = lim_w;
      end else if (cmd_w < -lim_w) begin
         cmd_w = -lim_w;
      end
      lane_in[1].rr = cmd_w;
      lim_w = {1'b0, max_pitch_ff};
      cmd_w = s0_ff.pitch_rate_cmd;
      if (cmd_w > lim_w) begin
         cmd_w = lim_w;
      end else if (cmd_w < -lim_w) begin
         cmd_w = -lim_w;
      end
      lane_in[1].pr = cmd_w;

      diff_w = 33'({s0_ff.speed[31], s0_ff.speed} - {ref_speed_ff[31], ref_speed_ff});
      prod_w = radius_slope_ff * diff_w;
      lane_in[1].prod = prod_w[63:0];

      // stage 2: radius in Q32.32, held to the int64 range
      sum_w = {{18{base_radius_ff[31]}}, base_radius_ff, 16'b0}
            + {{2{lane_ff[1].prod[63]}}, lane_ff[1].prod};
      if (sum_w[65:63] == 3'b000 || sum_w[65:63] == 3'b111) begin
         lane_in[2].len = sum_w[63:0];
      end else if (sum_w[65]) begin
         lane_in[2].len = 64'sh8000_0000_0000_0000;
      end else begin
         lane_in[2].len = 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      lane_in[2].lenpos = !lane_in[2].len[63] && (lane_in[2].len != '0);

      // first multiply stage
      lane_in[ST_MUL].xy = 33'(mul_q30({lane_ff[ST_TRIG].spd[31], lane_ff[ST_TRIG].spd},
                                       cos_pitch));
      lane_in[ST_MUL].down = sat32(35'(-mul_q30({lane_ff[ST_TRIG].spd[31],
                                                 lane_ff[ST_TRIG].spd}, sin_pitch)));
      spd_m = lane_ff[ST_TRIG].spd[31] ? 32'(-lane_ff[ST_TRIG].spd)
                                       : 32'(lane_ff[ST_TRIG].spd);
      sr_m  = sin_roll[31] ? 31'(-sin_roll) : sin_roll[30:0];
      cr_m  = cos_roll[31] ? 31'(-cos_roll) : cos_roll[30:0];
      num_w = {31'b0, spd_m} * {32'b0, sr_m};
      lane_in[ST_MUL].num = num_w[61:0];
      lane_in[ST_MUL].neg = lane_ff[ST_TRIG].spd[31] ^ sin_roll[31] ^ cos_roll[31];
      lane_in[ST_MUL].dlo = {31'b0, lane_ff[ST_TRIG].len[31:0]} * {32'b0, cr_m};
      lane_in[ST_MUL].dhi = {31'b0, lane_ff[ST_TRIG].len[62:32]} * {31'b0, cr_m};
      lane_in[ST_MUL].ch  = cos_head;
      lane_in[ST_MUL].sh  = sin_head;

      // second multiply stage, divisor assembly
      lane_in[ST_POS].north = sat32(mul_q30(lane_ff[ST_MUL].xy, lane_ff[ST_MUL].ch));
      lane_in[ST_POS].east  = sat32(mul_q30(lane_ff[ST_MUL].xy, lane_ff[ST_MUL].sh));
      dsum_w = {31'b0, lane_ff[ST_MUL].dlo} + {lane_ff[ST_MUL].dhi, 32'b0};
      lane_in[ST_POS].d     = dsum_w[DW-1:0];
      lane_in[ST_POS].rem   = {lane_ff[ST_MUL].num, 32'b0};
      lane_in[ST_POS].numnz = (lane_ff[ST_MUL].num != '0);

      // quotient would reach 2^31, or the divisor is zero (cos(roll) or radius zero)
      lane_in[ST_CHK].ovf = (lane_ff[ST_POS].d == '0)
                         || ({(CW-NW)'(0), lane_ff[ST_POS].rem}
                             >= {lane_ff[ST_POS].d, (QW)'(0)});
      lane_in[ST_CHK].q = '0;

      // restoring divide, one quotient bit per stage, MSB first
      for (int j = 0; j < QW; j++) begin
         r_w = {(CW-NW)'(0), lane_ff[ST_DIV0+j-1].rem};
         t_w = {(QW)'(0), lane_ff[ST_DIV0+j-1].d} << (QW - 1 - j);
         sub_w = r_w - t_w;
         if (r_w >= t_w) begin
            lane_in[ST_DIV0+j].rem = sub_w[NW-1:0];
            lane_in[ST_DIV0+j].q[QW-1-j] = 1'b1;
         end
      end

      // output stage
      sat_w = lane_ff[ST_OUT-1].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      if (!lane_ff[ST_OUT-1].lenpos) begin
         lane_in[ST_OUT].flag = 1'b1;
         lane_in[ST_OUT].yaw  = lane_ff[ST_OUT-1].numnz ? sat_w : 32'sd0;
      end else if (lane_ff[ST_OUT-1].numnz) begin
         if (lane_ff[ST_OUT-1].ovf) begin
            lane_in[ST_OUT].flag = 1'b1;
            lane_in[ST_OUT].yaw  = sat_w;
         end else begin
            lane_in[ST_OUT].flag = 1'b0;
            lane_in[ST_OUT].yaw  = lane_ff[ST_OUT-1].neg ? -{1'b0, lane_ff[ST_OUT-1].q}
                                                         : {1'b0, lane_ff[ST_OUT-1].q};
         end
      end else begin
         lane_in[ST_OUT].flag = 1'b0;
         lane_in[ST_OUT].yaw  = 32'sd0;
      end
   end

   always_comb begin
      rsp_data.north_rate     = lane_ff[ST_OUT].north;
      rsp_data.east_rate      = lane_ff[ST_OUT].east;
      rsp_data.down_rate      = lane_ff[ST_OUT].down;
      rsp_data.roll_rate_out  = lane_ff[ST_OUT].rr;
      rsp_data.pitch_rate_out = lane_ff[ST_OUT].pr;
      rsp_data.yaw_rate_out   = lane_ff[ST_OUT].yaw;
      rsp_data.speed_rate_out = lane_ff[ST_OUT].spdr;
      rsp_data.yaw_saturated  = lane_ff[ST_OUT].flag;
   end

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted beat did not enter stage 0");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      !reset && !(rsp_valid && rsp_ready)
      |=> $countones(vld_ff) >= $past($countones(vld_ff)))
      else $error("beat dropped inside pipeline");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_ready |-> !req_ready)
      else $error("full pipe took a beat");

   a_speed_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.speed_rate_out <= 32'sd1310720
                     && rsp_data.speed_rate_out >= -32'sd1310720))
      else $error("speed rate outside throttle range");
`endif

endmodule
`default_nettype wire

// File: design/akd_sin_pipe.sv
`default_nettype none
module akd_sin_pipe
   import akd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [SIN_STAGES-1:0]  en,
   input  wire logic [15:0]            angle,
   output logic signed [31:0]          sin_q30
);

   typedef struct packed {
      logic [30:0] x;
      logic [30:0] x2;
      logic [31:0] p;
      logic        neg;
   } sin_stage_type;

   sin_stage_type st_ff [0:SIN_STAGES-2];
   sin_stage_type st_in [0:SIN_STAGES-2];
   logic signed [31:0] sin_ff;
   logic signed [31:0] sin_in;

   logic [14:0] r_w;
   logic [30:0] x_w;
   logic [61:0] xx_w;
   logic [63:0] hp_w;
   logic [63:0] fp_w;
   logic [33:0] m_w;

   always_comb begin
      // fold into first quadrant
      r_w  = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      x_w  = {r_w, 16'b0};
      xx_w = ({31'b0, x_w} * {31'b0, x_w}) + HALF30[61:0];
      st_in[0].x   = x_w;
      st_in[0].x2  = xx_w[60:30];
      st_in[0].p   = SIN_COEF[5];
      st_in[0].neg = angle[15];
      for (int j = 1; j < SIN_STAGES - 1; j++) begin
         st_in[j] = st_ff[j-1];
         hp_w = ({32'b0, st_ff[j-1].p} * {33'b0, st_ff[j-1].x2}) + HALF30;
         st_in[j].p = SIN_COEF[SIN_STAGES-2-j] - hp_w[61:30];
      end
      fp_w = ({32'b0, st_ff[SIN_STAGES-2].p} * {33'b0, st_ff[SIN_STAGES-2].x}) + HALF30;
      m_w  = fp_w[63:30];
      if (m_w > 34'h0_4000_0000) begin
         m_w = 34'h0_4000_0000;
      end
      sin_in = st_ff[SIN_STAGES-2].neg ? 32'(-m_w) : 32'(m_w);
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < SIN_STAGES - 1; j++) begin
         if (en[j]) begin
            st_ff[j] <= st_in[j];
         end
      end
      if (en[SIN_STAGES-1]) begin
         sin_ff <= sin_in;
      end
   end

   assign sin_q30 = sin_ff;

endmodule
`default_nettype wire
